// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check expr at every rising clk edge, skipping cycles in reset.
`define PLA_ASSERT(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);
// Check that cond at one edge implies expr at the next edge.
`define PLA_ASSERT_NEXT(lbl, clk, rstn, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error(msg);
`else
`define PLA_ASSERT(lbl, clk, rstn, expr, msg)
`define PLA_ASSERT_NEXT(lbl, clk, rstn, cond, expr, msg)
`endif

`endif

// ===== design/pla_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pla_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQSUM,
        ST_ROOT
    } pla_state_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_QUERY  = 1'b1
    } pla_op_t;

endpackage

`default_nettype wire

// ===== design/pla_sqsum.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial sum of three squares, multiplier bits taken MSB first.
module pla_sqsum #(
    parameter int MAG_W = 25
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [MAG_W-1:0]     mag_x,
    input  wire logic [MAG_W-1:0]     mag_y,
    input  wire logic [MAG_W-1:0]     mag_z,
    output logic                      done,
    output logic [2*MAG_W-1:0]        sum
);

    localparam int SUM_W = 2 * MAG_W;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0] mx_reg, my_reg, mz_reg;
    logic [MAG_W-1:0] bx_reg, by_reg, bz_reg;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SUM_W-1:0] partial;

    always_comb begin
        partial = (bx_reg[MAG_W-1] ? SUM_W'(mx_reg) : '0)
                + (by_reg[MAG_W-1] ? SUM_W'(my_reg) : '0)
                + (bz_reg[MAG_W-1] ? SUM_W'(mz_reg) : '0);
        acc_next = {acc_reg[SUM_W-2:0], 1'b0} + partial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mx_reg  <= mag_x;
            my_reg  <= mag_y;
            mz_reg  <= mag_z;
            bx_reg  <= mag_x;
            by_reg  <= mag_y;
            bz_reg  <= mag_z;
            acc_reg <= '0;
        end else if (busy_reg) begin
            bx_reg  <= {bx_reg[MAG_W-2:0], 1'b0};
            by_reg  <= {by_reg[MAG_W-2:0], 1'b0};
            bz_reg  <= {bz_reg[MAG_W-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

`default_nettype wire

// ===== design/pla_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring digit-by-digit floor square root, one root bit per cycle.
module pla_sqrt #(
    parameter int ROOT_W = 25
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [2*ROOT_W-1:0]   radicand,
    output logic                       done,
    output logic [ROOT_W-1:0]          root
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              fits;

    always_comb begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        fits      = (rem_shift >= trial);
        rem_next  = fits ? (rem_shift - trial) : rem_shift;
        root_next = {root_reg[ROOT_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== design/path_length_accumulator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Path length accumulator. Each input transaction is either a position sample
// (s_op = 0) or a query (s_op = 1). The first sample after reset or after a
// query only stores its position. Every later sample adds the floor of the
// Euclidean distance to the stored position, sqrt(dx^2 + dy^2 + dz^2), to a
// saturating running total and stores the new position. A query returns
// the total on the m_ channel, clears it and re-arms the first-sample flag;
// its position fields are ignored. Positions are signed fixed point and the
// total is unsigned with the same number of fraction bits. A query or a first
// sample is handled without the datapath; a sample that adds a distance runs
// the bit-serial squaring unit (one multiplier bit per cycle for all three
// axes) followed by the digit-serial square root (one root bit per cycle).
// The input is ready only between samples. A query is taken as soon as the
// output register is free, so one result may wait on m_ready while a
// following sample is accepted and processed.
module path_length_accumulator_top #(
    parameter int COORD_WIDTH = 24,
    parameter int TOTAL_WIDTH = 48
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_op,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_z,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [TOTAL_WIDTH-1:0]          m_path_length
);

    import pla_pkg::*;

    `include "assert_macros.svh"

    // Magnitude of a coordinate difference needs one bit more than a
    // coordinate; the sum of three squares is held in twice that width.
    localparam int MAG_W = COORD_WIDTH + 1;
    localparam int SUM_W = 2 * MAG_W;
    localparam int ADD_W = ((TOTAL_WIDTH > MAG_W) ? TOTAL_WIDTH : MAG_W) + 1;

    pla_state_t state_reg, state_next;

    logic [COORD_WIDTH-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic                   awaiting_reg;
    logic [TOTAL_WIDTH-1:0] path_total_reg;
    logic                   m_valid_reg;
    logic [TOTAL_WIDTH-1:0] m_total_reg;

    logic                   out_free;
    logic                   s_accept;
    logic                   take_query;
    logic                   take_sample;
    logic                   start_sqsum;
    logic [MAG_W-1:0]       mag_x, mag_y, mag_z;
    logic                   sq_done;
    logic [SUM_W-1:0]       sq_sum;
    logic                   root_done;
    logic [MAG_W-1:0]       root_val;
    logic [ADD_W-1:0]       total_sum;
    logic [TOTAL_WIDTH-1:0] total_sat;

    // Absolute difference of two signed coordinates, one bit wider.
    function automatic logic [MAG_W-1:0] abs_delta(
        input logic [COORD_WIDTH-1:0] a,
        input logic [COORD_WIDTH-1:0] b
    );
        logic [MAG_W-1:0] d;
        d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        return d[MAG_W-1] ? (~d + MAG_W'(1)) : d;
    endfunction

    // ---------------------------------------------------------------
    // Handshake: samples only while idle, queries also need a free
    // output register.
    // ---------------------------------------------------------------
    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == ST_IDLE) && ((s_op == OP_SAMPLE) || out_free);
    assign s_accept    = s_valid && s_ready;
    assign take_query  = s_accept && (s_op == OP_QUERY);
    assign take_sample = s_accept && (s_op == OP_SAMPLE);
    assign start_sqsum = take_sample && !awaiting_reg;

    always_comb begin
        mag_x = abs_delta(s_pos_x, prev_x_reg);
        mag_y = abs_delta(s_pos_y, prev_y_reg);
        mag_z = abs_delta(s_pos_z, prev_z_reg);
    end

    // ---------------------------------------------------------------
    // Datapath units: squares first, then the root of their sum.
    // ---------------------------------------------------------------
    pla_sqsum #(
        .MAG_W (MAG_W)
    ) u_sqsum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_sqsum),
        .mag_x   (mag_x),
        .mag_y   (mag_y),
        .mag_z   (mag_z),
        .done    (sq_done),
        .sum     (sq_sum)
    );

    pla_sqrt #(
        .ROOT_W (MAG_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_done),
        .radicand (sq_sum),
        .done     (root_done),
        .root     (root_val)
    );

    // Saturating add of the new distance to the running total.
    always_comb begin
        total_sum = ADD_W'(path_total_reg) + ADD_W'(root_val);
        if (total_sum[ADD_W-1:TOTAL_WIDTH] != '0) begin
            total_sat = '1;
        end else begin
            total_sat = total_sum[TOTAL_WIDTH-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_sqsum) begin
                    state_next = ST_SQSUM;
                end
            end
            ST_SQSUM: begin
                if (sq_done) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Architectural state and output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_z_reg     <= '0;
            awaiting_reg   <= 1'b1;
            path_total_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // Drop the result once the consumer takes it; a query refills.
            if (take_query) begin
                m_valid_reg    <= 1'b1;
                path_total_reg <= '0;
                awaiting_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Hold the new position; the deltas are already with the squarer.
            if (take_sample) begin
                prev_x_reg   <= s_pos_x;
                prev_y_reg   <= s_pos_y;
                prev_z_reg   <= s_pos_z;
                awaiting_reg <= 1'b0;
            end

            // Advance the total when the root comes out.
            if (root_done) begin
                path_total_reg <= total_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_query) begin
            m_total_reg <= path_total_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_path_length = m_total_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `PLA_ASSERT_NEXT(a_query_clears, aclk, aresetn, take_query,
        m_valid && (path_total_reg == '0) && awaiting_reg, "query did not clear the total")
    `PLA_ASSERT_NEXT(a_total_monotonic, aclk, aresetn, !take_query,
        path_total_reg >= $past(path_total_reg), "total decreased without a query")
    `PLA_ASSERT(a_root_in_state, aclk, aresetn, !root_done || (state_reg == ST_ROOT),
        "root finished outside the root phase")
    `PLA_ASSERT(a_sq_in_state, aclk, aresetn, !sq_done || (state_reg == ST_SQSUM),
        "square sum finished outside the squaring phase")

endmodule

`default_nettype wire

// ===== tb/path_length_checker.sv =====
`timescale 1ns / 1ps

module path_length_checker #(
    parameter int COORD_WIDTH = 24,
    parameter int TOTAL_WIDTH = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_op,
    input  logic signed [COORD_WIDTH-1:0] s_pos_x,
    input  logic signed [COORD_WIDTH-1:0] s_pos_y,
    input  logic signed [COORD_WIDTH-1:0] s_pos_z,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [TOTAL_WIDTH-1:0]        m_path_length,
    output int                            mismatches,
    output int                            totals_waiting,
    output int                            totals_checked
);

    import pla_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [TOTAL_WIDTH-1:0]        total_t;

    // The root is searched over COORD_WIDTH+1 bits, the width of one delta.
    localparam int     ROOT_BITS = COORD_WIDTH + 1;
    localparam total_t TOTAL_MAX = '1;

    coord_t last_x;
    coord_t last_y;
    coord_t last_z;
    bit     first_sample;
    total_t odometer;
    total_t expected_totals[$];
    total_t oldest_total;
    int     error_count;
    int     checked_count;

    function automatic longint unsigned axis_square(coord_t a, coord_t b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        return longint'(d * d);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned cand;
        r = 0;
        for (int b = ROOT_BITS - 1; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            if (cand * cand <= v) r = cand;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, total_t want, total_t got);
        $display("checker: %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        error_count++;
    endtask

    // Advance the odometer by one accepted transaction.
    task automatic advance_odometer(pla_op_t op, coord_t x, coord_t y, coord_t z);
        longint unsigned step;
        longint unsigned headroom;
        if (op == OP_QUERY) begin
            expected_totals.push_back(odometer);
            odometer     = '0;
            first_sample = 1'b1;
        end else begin
            if (!first_sample) begin
                step = floor_root(axis_square(x, last_x) + axis_square(y, last_y)
                                  + axis_square(z, last_z));
                headroom = 64'(TOTAL_MAX - odometer);
                if (step > headroom) odometer = TOTAL_MAX;
                else odometer = odometer + total_t'(step);
            end
            first_sample = 1'b0;
            last_x = x;
            last_y = y;
            last_z = z;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            last_x       = '0;
            last_y       = '0;
            last_z       = '0;
            first_sample = 1'b1;
            odometer     = '0;
            expected_totals.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_totals.size() == 0) begin
                    report_mismatch("path_length with no query outstanding", '0,
                                    m_path_length);
                end else begin
                    oldest_total = expected_totals.pop_front();
                    checked_count++;
                    if (m_path_length !== oldest_total)
                        report_mismatch("path_length", oldest_total, m_path_length);
                end
            end
            if (s_valid && s_ready)
                advance_odometer(pla_op_t'(s_op), s_pos_x, s_pos_y, s_pos_z);
        end
        mismatches     <= error_count;
        totals_waiting <= expected_totals.size();
        totals_checked <= checked_count;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import pla_pkg::*;

    localparam int COORD_WIDTH = 24;
    localparam int TOTAL_WIDTH = 48;
    // Generous ceiling on the run length.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Long back-pressure window, comfortably longer than several samples.
    localparam int LONG_HOLD   = 400;
    // Settling time, sized from the longest sample.
    localparam int SETTLE      = 2 * (2 * (COORD_WIDTH + 1) + 3);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic                   aclk    = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_op    = OP_SAMPLE;
    coord_t                 s_pos_x = '0;
    coord_t                 s_pos_y = '0;
    coord_t                 s_pos_z = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [TOTAL_WIDTH-1:0] m_path_length;

    int mismatches;
    int totals_waiting;
    int totals_checked;

    // Stimulus controls shared with the receiver process.
    bit idle_on   = 1'b1;
    bit hold_req  = 1'b0;
    int cycle_count = 0;
    int offered_count = 0;
    int query_count = 0;

    // Last sample position sent, used to build short random-walk moves.
    coord_t walk_x = '0;
    coord_t walk_y = '0;
    coord_t walk_z = '0;

    path_length_accumulator_top #(
        .COORD_WIDTH (COORD_WIDTH),
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pos_z       (s_pos_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_path_length (m_path_length)
    );

    path_length_checker #(
        .COORD_WIDTH (COORD_WIDTH),
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_path_length  (m_path_length),
        .mismatches     (mismatches),
        .totals_waiting (totals_waiting),
        .totals_checked (totals_checked)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: accept results with random stall bursts, and honor a request
    // for one long hold-off that lets a result back up into the block.
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req <= 1'b0;
                m_ready  <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one transaction and hold it until accepted. An optional idle
    // burst comes first; valid is lowered only when a gap is inserted.
    task automatic offer(pla_op_t op, coord_t x, coord_t y, coord_t z);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_pos_x <= x;
        s_pos_y <= y;
        s_pos_z <= z;
        do @(posedge aclk); while (!s_ready);
        offered_count++;
        if (op == OP_QUERY) begin
            query_count++;
        end else begin
            walk_x = x;
            walk_y = y;
            walk_z = z;
        end
    endtask

    task automatic sample(coord_t x, coord_t y, coord_t z);
        offer(OP_SAMPLE, x, y, z);
    endtask

    // Query with junk in the position fields, which the block must ignore.
    task automatic query();
        offer(OP_QUERY, coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
    endtask

    // Idle the sender until every outstanding total has been returned.
    // The checker's counters are registered, so wait for a clock edge before looking.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (totals_waiting != 0) @(posedge aclk);
    endtask

    // Pick one coordinate: mostly a short move from the last position,
    // otherwise a fully random value or an extreme.
    function automatic coord_t pick_coord(coord_t from);
        int unsigned mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            return from + coord_t'(int'($urandom_range(0, 4096)) - 2048);
        else if (mode < 8)
            return coord_t'($urandom());
        else
            case ($urandom_range(0, 4))
                0: return COORD_MAX;
                1: return COORD_MIN;
                2: return '0;
                3: return '1;
                default: return coord_t'(1);
            endcase
    endfunction

    // Random traffic: sample paths of random length, each closed by a random query
    // (about one transaction in twelve).
    task automatic random_traffic(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0)
                query();
            else
                sample(pick_coord(walk_x), pick_coord(walk_y), pick_coord(walk_z));
        end
    endtask

    initial begin
        // Hold reset, then release it.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty total, then the extremes of every axis.
        query();
        sample(COORD_MAX, COORD_MAX, COORD_MAX);
        sample(COORD_MIN, COORD_MIN, COORD_MIN);
        sample(COORD_MAX, COORD_MIN, COORD_MAX);
        query();
        query();
        // A lone first sample adds nothing.
        sample(COORD_MIN, COORD_MAX, coord_t'(-1));
        query();
        // Zero, unit, sub-unit and exact-square moves.
        sample('0, '0, '0);
        sample('0, '0, '0);
        sample(coord_t'(1), '0, '0);
        sample(coord_t'(2), coord_t'(1), '0);
        sample(coord_t'(5), coord_t'(5), '0);
        sample(coord_t'(3), coord_t'(2), coord_t'(6));
        sample(coord_t'(-1), coord_t'(-1), coord_t'(-1));
        sample(COORD_MAX, coord_t'(-1), coord_t'(-1));
        sample(COORD_MIN, coord_t'(-1), coord_t'(-1));
        query();
        // Large jumps straddling the sign boundary.
        sample(coord_t'(-1), coord_t'(1), COORD_MIN);
        sample(coord_t'(1), coord_t'(-1), COORD_MAX);
        query();
        drain();

        random_traffic(600);

        // Hold the receiver off while offering queries back to back: one
        // total parks in the output register and the next query stalls.
        hold_req <= 1'b1;
        query();
        sample(pick_coord(walk_x), pick_coord(walk_y), pick_coord(walk_z));
        sample(pick_coord(walk_x), pick_coord(walk_y), pick_coord(walk_z));
        query();
        query();
        sample(pick_coord(walk_x), pick_coord(walk_y), pick_coord(walk_z));
        query();
        query();
        // Pause until every total has come back.
        drain();

        random_traffic(750);

        // Stream the tail with no idling on either side.
        idle_on <= 1'b0;
        random_traffic(150);
        query();
        drain();
        repeat (SETTLE) @(posedge aclk);

        $display("tb: %0d transactions offered, %0d of them queries; %0d totals compared",
                 offered_count, query_count, totals_checked);
        $display("tb: covered coordinate extremes, random walks, long back-pressure, streaming");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
